>>> design/pcs_pkg.sv
// Shared types, sizes and codes of the packed three-bit cell store.
package pcs_pkg;

	// Store geometry.
	localparam int STORE_BYTES = 256;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CAP_W       = ADDR_W + 1;

	// Field and register widths.
	localparam int REQ_W    = 2;
	localparam int INDEX_W  = 10;
	localparam int CELL_W   = 3;
	localparam int CAPREG_W = 9;
	localparam int GRID_W   = 7;
	localparam int CFGIDX_W = 2;
	localparam int CFGDAT_W = 9;

	// Derived widths: bit offset of a cell, byte position, active byte count.
	localparam int BIT_W  = INDEX_W + 2;
	localparam int POS_W  = BIT_W - 3;
	localparam int BITS_W = 2 * GRID_W + 2;
	localparam int ACT_W  = BITS_W - 3;

	localparam logic [7:0] CELL_MASK = 8'h07;
	localparam int         CELL_EDGE = 5;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// Register indexes.
	localparam logic [CFGIDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFGIDX_W-1:0] CFG_ROWS     = 2'd1;
	localparam logic [CFGIDX_W-1:0] CFG_COLS     = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [INDEX_W-1:0] cell_index;
		logic [CELL_W-1:0]  cell_value;
	} in_word_t;

	typedef struct packed {
		logic [CELL_W-1:0] read_value;
		logic              index_ok;
	} out_word_t;

	// Settings seen by the sequencer, worked out from the registers.
	typedef struct packed {
		logic [CAP_W-1:0] cap;
		logic [ACT_W-1:0] active;
		logic [2:0]       rem;
	} cfg_view_t;

endpackage

>>> design/pcs_byte_ram.sv
// Generic single-write, single-read synchronous RAM with write-first bypass.
module pcs_byte_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] mem_rd_q;
	logic [DATA_W-1:0] wdata_q;
	logic              hit_q;

	// Array write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_rd_q <= mem[raddr];
		wdata_q  <= wdata;
		hit_q    <= we && (waddr == raddr);
	end

	// A read at the address being written returns the new data.
	assign rdata = hit_q ? wdata_q : mem_rd_q;

endmodule

>>> design/pcs_cfg_regs.sv
// Configuration registers and the capacity and active size derived from them.
module pcs_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pcs_pkg::CFGIDX_W-1:0]     cfg_index,
	input  logic [pcs_pkg::CFGDAT_W-1:0]     cfg_data,
	output pcs_pkg::cfg_view_t               view
);
	import pcs_pkg::*;

	logic [CAPREG_W-1:0] capacity_q;
	logic [GRID_W-1:0]   rows_q;
	logic [GRID_W-1:0]   cols_q;
	logic [BITS_W-1:0]   prod;
	logic [BITS_W-1:0]   bits;
	logic [BITS_W-1:0]   rounded;

	assign cfg_ready = 1'b1;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPREG_W'(256);
			rows_q     <= '0;
			cols_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CAPACITY: capacity_q <= cfg_data[CAPREG_W-1:0];
				CFG_ROWS:     rows_q     <= cfg_data[GRID_W-1:0];
				CFG_COLS:     cols_q     <= cfg_data[GRID_W-1:0];
				default:      ;
			endcase
		end
	end

	// Capacity saturates at the store size.
	assign view.cap = (32'(capacity_q) < 32'(STORE_BYTES)) ? CAP_W'(capacity_q)
		: CAP_W'(STORE_BYTES);

	// Active size: three bits per grid cell, rounded up to whole bytes.
	assign prod        = BITS_W'(rows_q) * BITS_W'(cols_q);
	assign bits        = prod + (prod << 1);
	assign rounded     = bits + BITS_W'(7);
	assign view.active = rounded[BITS_W-1:3];
	assign view.rem    = bits[2:0];

endmodule

>>> design/pcs_ctrl.sv
// Request sequencer: read-modify-write over the byte RAM, valid bits and result register.
module pcs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pcs_pkg::in_word_t             in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pcs_pkg::out_word_t            out_word,
	input  pcs_pkg::cfg_view_t            view,
	output logic                          ram_we,
	output logic [pcs_pkg::ADDR_W-1:0]    ram_waddr,
	output logic [7:0]                    ram_wdata,
	output logic [pcs_pkg::ADDR_W-1:0]    ram_raddr,
	input  logic [7:0]                    ram_rdata
);
	import pcs_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_FIRST, ST_WIPE, ST_SECOND} state_t;

	state_t            state_q;
	logic              out_valid_q;
	out_word_t         out_q;
	logic [REQ_W-1:0]  req_q;
	logic [POS_W-1:0]  pos_q;
	logic [2:0]        off_q;
	logic [CELL_W-1:0] val_q;
	logic [CELL_W-1:0] part_q;
	logic              ok_q;
	logic              straddle_q;
	logic [CAP_W-1:0]  wipe_q;

	logic [STORE_BYTES-1:0] valid_q;
	logic                   rd_vld_q;

	logic              accept;
	logic              out_free;
	logic              leave;
	logic              wipe_more;
	logic [BIT_W-1:0]  in_bit;
	logic [POS_W-1:0]  in_pos;
	logic [POS_W:0]    pos_next;
	logic [ACT_W-1:0]  act_last;
	logic [7:0]        byte_rd;
	logic              ok0;
	logic              straddle;
	logic              mask_en;
	logic [CAP_W-1:0]  zero_lo;
	logic [10:0]       wide_val;
	logic [10:0]       wide_mask;
	logic [10:0]       wide_rd;
	logic [10:0]       wide_hi;
	logic [3:0]        low_bits;
	logic [7:0]        new0;
	logic [7:0]        new1;
	logic [7:0]        cut0;
	logic [7:0]        keep_rem;
	logic [2:0]        hi_mask;
	logic [CELL_W-1:0] part0;
	logic [CELL_W-1:0] full_val;

	// Handshake: a new word enters from idle, or as the previous result is loaded.
	assign out_free  = !out_valid_q || out_ready;
	assign leave     = (state_q == ST_SECOND) && out_free;
	assign in_ready  = (state_q == ST_IDLE) || leave;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// Byte position and offset of the incoming cell.
	assign in_bit   = BIT_W'(in_word.cell_index) + (BIT_W'(in_word.cell_index) << 1);
	assign in_pos   = in_bit[BIT_W-1:3];
	assign pos_next = {1'b0, pos_q} + (POS_W + 1)'(1);
	assign act_last = view.active - ACT_W'(1);

	// Read address: the first byte (for a clear, the last active byte) as a word enters, then the following byte.
	always_comb begin
		if ((state_q == ST_FIRST) || ((state_q == ST_SECOND) && !out_free)) begin
			ram_raddr = pos_next[ADDR_W-1:0];
		end else if (in_word.req_type == REQ_CLEAR) begin
			ram_raddr = act_last[ADDR_W-1:0];
		end else begin
			ram_raddr = in_pos[ADDR_W-1:0];
		end
	end

	// A byte that was never written since reset reads as zero.
	assign byte_rd = rd_vld_q ? ram_rdata : 8'h00;

	// Range tests against the capacity.
	assign ok0      = 32'(pos_q) < 32'(view.cap);
	assign straddle = (32'(off_q) > 32'(CELL_EDGE)) && (32'(pos_next) < 32'(view.cap));
	assign mask_en  = (view.active != '0) && (view.rem != 3'd0)
		&& (32'(act_last) < 32'(view.cap));
	assign zero_lo  = (32'(view.active) < 32'(view.cap)) ? CAP_W'(view.active) : view.cap;

	// Clear-unused zeroes one byte a cycle until the capacity is reached.
	assign wipe_more = 32'(wipe_q) < 32'(view.cap);

	// First byte: extract, merge or mask.
	assign wide_val  = 11'(val_q) << off_q;
	assign wide_mask = 11'(CELL_MASK) << off_q;
	assign wide_rd   = 11'(byte_rd) >> off_q;
	assign part0     = wide_rd[CELL_W-1:0];
	assign new0      = (byte_rd & ~wide_mask[7:0]) | wide_val[7:0];
	assign keep_rem  = 8'((9'd1 << view.rem) - 9'd1);
	assign cut0      = byte_rd & keep_rem;

	// Second byte of a straddling cell.
	assign low_bits = 4'd8 - 4'(off_q);
	assign wide_hi  = 11'(byte_rd) << low_bits;
	assign full_val = part_q | wide_hi[CELL_W-1:0];
	assign hi_mask  = (off_q == 3'd7) ? 3'b011 : 3'b001;
	assign new1     = (byte_rd & ~{5'b0, hi_mask}) | 8'(val_q >> low_bits);

	// Write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q[ADDR_W-1:0];
		ram_wdata = new0;
		if (state_q == ST_FIRST) begin
			if ((req_q == REQ_WRITE) && ok0) begin
				ram_we = 1'b1;
			end else if ((req_q == REQ_CLEAR) && mask_en) begin
				ram_we    = 1'b1;
				ram_waddr = act_last[ADDR_W-1:0];
				ram_wdata = cut0;
			end
		end else if (state_q == ST_WIPE) begin
			if (wipe_more) begin
				ram_we    = 1'b1;
				ram_waddr = wipe_q[ADDR_W-1:0];
				ram_wdata = 8'h00;
			end
		end else if (leave && (req_q == REQ_WRITE) && straddle_q) begin
			ram_we    = 1'b1;
			ram_waddr = pos_next[ADDR_W-1:0];
			ram_wdata = new1;
		end
	end

	// Valid bits: all clear after reset, set as each byte is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			rd_vld_q <= valid_q[ram_raddr] || (ram_we && (ram_waddr == ram_raddr));
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			req_q       <= REQ_READ;
			pos_q       <= '0;
			off_q       <= '0;
			val_q       <= '0;
			part_q      <= '0;
			ok_q        <= 1'b0;
			straddle_q  <= 1'b0;
			wipe_q      <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					part_q     <= part0;
					ok_q       <= ok0;
					straddle_q <= straddle;
					wipe_q     <= zero_lo;
					state_q    <= (req_q == REQ_CLEAR) ? ST_WIPE : ST_SECOND;
				end
				ST_WIPE: begin
					if (wipe_more) begin
						wipe_q <= wipe_q + CAP_W'(1);
					end else begin
						state_q <= ST_SECOND;
					end
				end
				ST_SECOND: begin
					if (leave) begin
						out_valid_q <= 1'b1;
						case (req_q)
							REQ_READ: begin
								out_q.read_value <= ok_q ? (straddle_q ? full_val : part_q)
									: '0;
								out_q.index_ok   <= ok_q;
							end
							REQ_WRITE: begin
								out_q.read_value <= '0;
								out_q.index_ok   <= ok_q;
							end
							default: begin
								out_q <= '0;
							end
						endcase
						state_q <= accept ? ST_FIRST : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (accept) begin
				req_q <= in_word.req_type;
				pos_q <= in_pos;
				off_q <= in_bit[2:0];
				val_q <= in_word.cell_value;
			end
		end
	end

endmodule

>>> design/packed_3bit_cell_store_top.sv
// Top level of the packed three-bit cell store.
//
// A store of 256 bytes holds three-bit cells packed from the least significant bit up, so that
// cell i begins at bit 3*i and may straddle two bytes. Each request word (read, write or
// clear-unused) gives one result word. A read or write goes through the single read port of
// the byte RAM in turn: the first byte is read as the word is taken, the second byte in the next
// cycle, and writes go back in between, so a new word is taken only as the result of the last
// one is loaded. Clear-unused masks the stray bits of the last active byte through the RAM in
// the same way and then zeroes the bytes from the active count up to the capacity one per
// cycle. A valid bit per byte, cleared by reset, makes bytes never written read as zero, so
// the store is usable straight after reset with no clearing pass. The user must write the
// registers on their own port only while the block is idle; the block itself does not
// enforce it.
module packed_3bit_cell_store_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pcs_pkg::in_word_t             in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pcs_pkg::out_word_t            out_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pcs_pkg::CFGIDX_W-1:0]  cfg_index,
	input  logic [pcs_pkg::CFGDAT_W-1:0]  cfg_data
);
	import pcs_pkg::*;

	cfg_view_t         view;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	// Configuration registers.
	pcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.view      (view)
	);

	// Request sequencer.
	pcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.view      (view),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Byte store.
	pcs_byte_ram #(
		.DATA_W (8),
		.DEPTH  (STORE_BYTES),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> tb/packed_3bit_cell_store_top_test.sv
// Self-checking testbench for the packed three-bit cell store, with a mirrored byte store.
`timescale 1ns / 1ps

import pcs_pkg::*;

// Mirror of the byte store and its registers, plus the queue of result words still due.
class cell_store_board;
	logic [7:0] byte_mirror [STORE_BYTES];
	logic [CAPREG_W-1:0] capacity;
	logic [GRID_W-1:0] rows;
	logic [GRID_W-1:0] cols;
	out_word_t due_results [$];
	int mismatches;

	function new();
		foreach (byte_mirror[i]) byte_mirror[i] = 8'h00;
		capacity = CAPREG_W'(STORE_BYTES);
		rows = '0;
		cols = '0;
		mismatches = 0;
	endfunction

	function void set_register(logic [CFGIDX_W-1:0] idx, logic [CFGDAT_W-1:0] data);
		case (idx)
			CFG_CAPACITY: capacity = data[CAPREG_W-1:0];
			CFG_ROWS: rows = data[GRID_W-1:0];
			CFG_COLS: cols = data[GRID_W-1:0];
			default: ;
		endcase
	endfunction

	// The capacity saturates at the size of the store.
	function int usable_bytes();
		return (int'(capacity) < STORE_BYTES) ? int'(capacity) : STORE_BYTES;
	endfunction

	// Applies one accepted request word to the mirror and queues the word it must produce.
	function void note_request(in_word_t w);
		int cap, bitpos, pos, off, value, lo_bits, hi_mask, mask, nbits, active, rem;
		out_word_t r;
		cap = usable_bytes();
		bitpos = int'(w.cell_index) * 3;
		pos = bitpos >> 3;
		off = bitpos & 7;
		value = int'(w.cell_value);
		lo_bits = 8 - off;
		r = '0;
		case (w.req_type)
			REQ_READ: begin
				if (pos < cap) begin
					r.index_ok = 1'b1;
					value = (int'(byte_mirror[pos]) >> off) & int'(CELL_MASK);
					if (off > CELL_EDGE && pos + 1 < cap)
						value |= (int'(byte_mirror[pos + 1]) << lo_bits) & int'(CELL_MASK);
					r.read_value = value[CELL_W-1:0];
				end
			end
			REQ_WRITE: begin
				if (pos < cap) begin
					r.index_ok = 1'b1;
					mask = (int'(CELL_MASK) << off) & 8'hff;
					byte_mirror[pos] = 8'((int'(byte_mirror[pos]) & ~mask) | ((value << off) & 8'hff));
					// The high bits of a straddling cell go to the next byte when it is in range.
					if (off > CELL_EDGE && pos + 1 < cap) begin
						hi_mask = (1 << (3 - lo_bits)) - 1;
						byte_mirror[pos + 1] = 8'((int'(byte_mirror[pos + 1]) & ~hi_mask)
							| (value >> lo_bits));
					end
				end
			end
			REQ_CLEAR: begin
				nbits = int'(rows) * int'(cols) * 3;
				active = (nbits + 7) >> 3;
				rem = nbits & 7;
				if (active > 0 && rem != 0 && active - 1 < cap)
					byte_mirror[active - 1] = 8'(int'(byte_mirror[active - 1]) & ((1 << rem) - 1));
				if (active > cap)
					active = cap;
				for (int i = active; i < cap; i++)
					byte_mirror[i] = 8'h00;
			end
			default: ;
		endcase
		due_results.push_back(r);
	endfunction

	// Compares one result word with the oldest one due.
	function void check_result(out_word_t got);
		out_word_t want;
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected result word: read_value %0d index_ok %0d",
					got.read_value, got.index_ok);
		end else begin
			want = due_results.pop_front();
			if (got.read_value !== want.read_value || got.index_ok !== want.index_ok) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result mismatch at %0t: read_value exp %0d got %0d, index_ok exp %0d got %0d",
						$realtime, want.read_value, got.read_value, want.index_ok, got.index_ok);
			end
		end
	endfunction
endclass

module packed_3bit_cell_store_top_test;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_GAP      = 24;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFGIDX_W-1:0] cfg_index;
	logic [CFGDAT_W-1:0] cfg_data;

	cell_store_board board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int written_cells [$];

	packed_3bit_cell_store_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock of 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: ready follows the stall rate, or stays low through a requested hold-off.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_stall_pct > 0) begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Every accepted result word is checked against the mirror.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_word);
	end

	// Watchdog on cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_word_t make_word(logic [REQ_W-1:0] req, int idx, int value);
		in_word_t w;
		w.req_type = req;
		w.cell_index = INDEX_W'(idx);
		w.cell_value = CELL_W'(value);
		return w;
	endfunction

	// Number of idle cycles before the next request word.
	function automatic int pick_gap();
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		return gap;
	endfunction

	// Random request: mostly writes and reads within capacity, reads often revisit written cells.
	function automatic in_word_t next_request();
		int cap, span, sel, idx, kind;
		logic [REQ_W-1:0] req;
		cap = board.usable_bytes();
		span = (cap * 8 + 2) / 3;
		kind = $urandom_range(99);
		if (kind < 45)
			req = REQ_READ;
		else if (kind < 90)
			req = REQ_WRITE;
		else if (kind < 96)
			req = REQ_CLEAR;
		else
			req = 2'd3;
		sel = $urandom_range(99);
		if (sel < 10 || span == 0)
			idx = $urandom_range(1023);
		else if (sel < 24)
			idx = span - 3 + $urandom_range(5);
		else
			idx = $urandom_range(span - 1);
		if (idx < 0)
			idx = 0;
		if (idx > 1023)
			idx = 1023;
		if (req == REQ_READ && written_cells.size() > 0 && $urandom_range(1) == 1)
			idx = written_cells[$urandom_range(written_cells.size() - 1)];
		if (req == REQ_WRITE) begin
			written_cells.push_back(idx);
			if (written_cells.size() > 32)
				void'(written_cells.pop_front());
		end
		return make_word(req, idx, $urandom_range(7));
	endfunction

	// Offers one request word after the given gap and holds it until it is taken.
	task automatic push_word(in_word_t w, int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		board.note_request(w);
	endtask

	task automatic write_reg(logic [CFGIDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFGDAT_W'(value);
		do @(posedge clk); while (!cfg_ready);
		board.set_register(idx, CFGDAT_W'(value));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every result is in and the block has had time to settle.
	task automatic wait_idle();
		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One phase: new register settings, then random requests under the given idle rates.
	task automatic run_phase(int cap, int rows, int cols, int send_pct, int recv_pct, int count,
			bit hold);
		wait_idle();
		write_reg(CFG_CAPACITY, cap);
		write_reg(CFG_ROWS, rows);
		write_reg(CFG_COLS, cols);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		hold_request = hold;
		repeat (count) push_word(next_request(), pick_gap());
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	initial begin
		int mode;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words at reset settings: straddling cells, the last byte, out of range cells,
		// the unused code and a clear that empties the whole store.
		push_word(make_word(REQ_WRITE, 0, 7), 0);
		push_word(make_word(REQ_READ, 0, 0), 0);
		push_word(make_word(REQ_WRITE, 2, 5), 0);
		push_word(make_word(REQ_READ, 2, 0), 0);
		push_word(make_word(REQ_READ, 1, 7), 0);
		push_word(make_word(REQ_READ, 3, 0), 0);
		push_word(make_word(REQ_WRITE, 5, 6), 0);
		push_word(make_word(REQ_READ, 5, 0), 0);
		push_word(make_word(REQ_WRITE, 4, 3), 0);
		push_word(make_word(REQ_READ, 5, 0), 0);
		push_word(make_word(REQ_WRITE, 681, 7), 0);
		push_word(make_word(REQ_WRITE, 682, 7), 0);
		push_word(make_word(REQ_READ, 682, 0), 0);
		push_word(make_word(REQ_READ, 681, 0), 0);
		push_word(make_word(REQ_WRITE, 683, 1), 0);
		push_word(make_word(REQ_READ, 683, 0), 0);
		push_word(make_word(REQ_WRITE, 1023, 7), 0);
		push_word(make_word(REQ_READ, 1023, 0), 0);
		push_word(make_word(2'd3, 1023, 7), 0);
		push_word(make_word(2'd3, 0, 0), 0);
		push_word(make_word(REQ_READ, 2, 0), 0);
		push_word(make_word(REQ_CLEAR, 1023, 7), 0);
		push_word(make_word(REQ_READ, 0, 0), 0);
		push_word(make_word(REQ_READ, 682, 0), 0);
		@(negedge clk);
		in_valid <= 1'b0;

		// Fixed settings covering the register extremes, then random ones.
		run_phase(256, 8, 8, 0, 0, 120, 1'b0);
		run_phase(5, 1, 1, 65, 0, 80, 1'b0);
		run_phase(1, 127, 127, 0, 65, 60, 1'b0);
		run_phase(0, 0, 0, 0, 65, 20, 1'b0);
		run_phase(511, 64, 64, 7, 7, 120, 1'b0);
		run_phase(300, 3, 5, 0, 0, 120, 1'b1);
		run_phase(2, 0, 127, 65, 0, 40, 1'b0);
		for (int p = 0; p < 3; p++) begin
			mode = $urandom_range(3);
			run_phase(($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(256, 1),
				($urandom_range(1) == 0) ? $urandom_range(16) : $urandom_range(127),
				($urandom_range(1) == 0) ? $urandom_range(16) : $urandom_range(127),
				(mode == 1) ? 65 : (mode == 3) ? 7 : 0,
				(mode == 2) ? 65 : (mode == 3) ? 7 : 0, 50, 1'b0);
		end

		wait_idle();
		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
